>>> src/mwq_pkg.sv
// mwq_pkg: shared types and constants of the moving-window quantile unit
// used by every module of the unit; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package mwq_pkg;

   localparam int WINDOW_MAX_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int STEP_MAX        = 1024;
   localparam int PROB_ONE        = 65536;
   localparam int ROW_BITS        = 32;
   localparam int QUANT_BITS      = 48;
   localparam int FRAC_BITS       = 16;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 17;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_SIZE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUANTILE_PROB = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_SIZE     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SKIP_MISSING  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ALIGNMENT     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COMPACT_INDEX = 3'd5;

   localparam logic [1:0] ALIGN_START = 2'd0;
   localparam logic [1:0] ALIGN_HALF  = 2'd1;

   // control of the cell chain, one copy fans out to every cell
   typedef struct packed {
      logic shift;      // new slot enters, window moves by one
      logic load_rank;  // copy own slot into circulating register, clear rank
      logic load_pick;  // copy own slot and rank into circulating register
      logic rotate;     // circulating registers move one cell on
      logic rank_en;    // compare against the circulating slot and count
   } cell_ctrl_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_LOAD1 = 8'b0000_0010,
      ST_RANK  = 8'b0000_0100,
      ST_POS   = 8'b0000_1000,
      ST_LOAD2 = 8'b0001_0000,
      ST_PICK  = 8'b0010_0000,
      ST_MUL   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

endpackage
`default_nettype wire

>>> src/mwq_cell.sv
// mwq_cell: one window slot of the cell chain, with a circulating copy and a rank counter
// depends on mwq_pkg
`timescale 1ns / 1ps
`default_nettype none
module mwq_cell #(
   parameter int WINDOW_MAX  = mwq_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = mwq_pkg::SAMPLE_BITS_DEF,
   parameter int POS         = 0
) (
   input  wire                               clock,
   input  wire mwq_pkg::cell_ctrl_type       ctrl,
   input  wire [$clog2(WINDOW_MAX):0]        window_n,
   input  wire signed [SAMPLE_BITS-1:0]      prev_value,
   input  wire                               prev_present,
   input  wire signed [SAMPLE_BITS-1:0]      circ_value_in,
   input  wire                               circ_elig_in,
   input  wire                               circ_win_in,
   input  wire [$clog2(WINDOW_MAX)-1:0]      circ_tag_in,
   output logic signed [SAMPLE_BITS-1:0]     value_out,
   output logic                              present_out,
   output logic signed [SAMPLE_BITS-1:0]     circ_value_out,
   output logic                              circ_elig_out,
   output logic                              circ_win_out,
   output logic [$clog2(WINDOW_MAX)-1:0]     circ_tag_out
);
   import mwq_pkg::*;

   localparam int AW = $clog2(WINDOW_MAX);
   localparam logic [AW:0]   POS_N   = (AW+1)'(POS);
   localparam logic [AW-1:0] POS_TAG = AW'(POS);

   logic signed [SAMPLE_BITS-1:0] value_ff;
   logic                          present_ff;
   logic signed [SAMPLE_BITS-1:0] circ_value_ff;
   logic                          circ_elig_ff;
   logic                          circ_win_ff;
   logic [AW-1:0]                 circ_tag_ff;
   logic [AW-1:0]                 rank_ff;
   logic [AW-1:0]                 rank_in;
   logic                          in_window;
   logic                          below;

   assign in_window = (POS_N < window_n);

   // stable order: equal values rank by slot position
   assign below = circ_elig_ff &&
                  ((circ_value_ff < value_ff) ||
                   ((circ_value_ff == value_ff) && (circ_tag_ff < POS_TAG)));

   assign rank_in = (ctrl.rank_en && below) ? rank_ff + AW'(1) : rank_ff;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         value_ff   <= prev_value;
         present_ff <= prev_present;
      end
      if (ctrl.load_rank) begin
         circ_value_ff <= value_ff;
         circ_elig_ff  <= present_ff && in_window;
         circ_win_ff   <= in_window;
         circ_tag_ff   <= POS_TAG;
         rank_ff       <= '0;
      end else if (ctrl.load_pick) begin
         circ_value_ff <= value_ff;
         circ_elig_ff  <= present_ff && in_window;
         circ_win_ff   <= in_window;
         circ_tag_ff   <= rank_ff;
      end else begin
         rank_ff <= rank_in;
         if (ctrl.rotate) begin
            circ_value_ff <= circ_value_in;
            circ_elig_ff  <= circ_elig_in;
            circ_win_ff   <= circ_win_in;
            circ_tag_ff   <= circ_tag_in;
         end
      end
   end

   assign value_out      = value_ff;
   assign present_out    = present_ff;
   assign circ_value_out = circ_value_ff;
   assign circ_elig_out  = circ_elig_ff;
   assign circ_win_out   = circ_win_ff;
   assign circ_tag_out   = circ_tag_ff;

endmodule
`default_nettype wire

>>> src/mwq_divider.sv
// mwq_divider: restoring divider, one quotient bit per cycle, for the compacted row index
// depends on mwq_pkg
`timescale 1ns / 1ps
`default_nettype none
module mwq_divider (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   input  wire [mwq_pkg::ROW_BITS-1:0]   dividend,
   input  wire [10:0]                    divisor,
   output logic                          done,
   output logic [mwq_pkg::ROW_BITS-1:0]  quotient
);
   import mwq_pkg::*;

   logic [ROW_BITS-1:0] quot_ff;
   logic [11:0]         rem_ff;
   logic [10:0]         dsr_ff;
   logic [5:0]          cnt_ff;
   logic                busy_ff;
   logic [11:0]         trial;
   logic                fits;

   assign trial = {rem_ff[10:0], quot_ff[ROW_BITS-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (cnt_ff == 6'(ROW_BITS - 1))
            busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= fits ? trial - {1'b0, dsr_ff} : trial;
         quot_ff <= {quot_ff[ROW_BITS-2:0], fits};
      end
   end

   assign done     = !busy_ff && !start;
   assign quotient = quot_ff;

endmodule
`default_nettype wire

>>> src/moving_window_quantile_unit.sv
// Moving-window quantile unit. One slot is taken per transfer on req_; once the window of
// window_size slots is full, every step_size-th window gives one result on rsp_. A slot
// that causes no result leaves the unit idle and ready. For a result the cell
// chain ranks the window by rotating a copy of every slot once around all WINDOW_MAX cells,
// then rotates once more to pick the two neighbors of the quantile position, then one
// multiply stage. The row divider for compact_index runs alongside, and the result waits
// for it. A finished result waits in the output register while the next
// slot is already taken. No clearing pass after reset.
// depends on mwq_pkg, mwq_cell, mwq_divider
`timescale 1ns / 1ps
`default_nettype none
module moving_window_quantile_unit #(
   parameter int WINDOW_MAX  = mwq_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = mwq_pkg::SAMPLE_BITS_DEF
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_tvalid,
   output logic                                      req_tready,
   // sample_value
   input  wire [((SAMPLE_BITS+7)/8)*8-1:0]           req_tdata,
   // sample_present, series_start
   input  wire [1:0]                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire                                       rsp_tready,
   // row_index, quantile_value
   output logic [mwq_pkg::ROW_BITS+mwq_pkg::QUANT_BITS-1:0] rsp_tdata,
   // quantile_missing
   output logic [0:0]                                rsp_tuser,
   input  wire                                       csr_we,
   input  wire [mwq_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  wire [mwq_pkg::CSR_DATA_BITS-1:0]          csr_wdata
);
   import mwq_pkg::*;

   localparam int AW = $clog2(WINDOW_MAX);
   localparam int NW = AW + 1;
   localparam int SB = SAMPLE_BITS;
   localparam int PW = SB + 18;
   localparam int QW = (PW > QUANT_BITS) ? PW : QUANT_BITS;

   // configuration
   logic [6:0]  win_size_ff;
   logic [16:0] prob_ff;
   logic [10:0] step_ff;
   logic        skip_ff;
   logic [1:0]  align_ff;
   logic        compact_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= 7'd1;
         prob_ff     <= 17'd32768;
         step_ff     <= 11'd1;
         skip_ff     <= 1'b0;
         align_ff    <= ALIGN_START;
         compact_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_WINDOW_SIZE:   win_size_ff <= csr_wdata[6:0];
            REG_QUANTILE_PROB: prob_ff     <= csr_wdata;
            REG_STEP_SIZE:     step_ff     <= csr_wdata[10:0];
            REG_SKIP_MISSING:  skip_ff     <= csr_wdata[0];
            REG_ALIGNMENT:     align_ff    <= csr_wdata[1:0];
            REG_COMPACT_INDEX: compact_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamped settings
   logic [NW-1:0] win_n;
   logic [10:0]   step_n;
   logic [16:0]   prob_n;

   always_comb begin
      if (win_size_ff == 7'd0)
         win_n = NW'(1);
      else if (32'(win_size_ff) > 32'(WINDOW_MAX))
         win_n = NW'(WINDOW_MAX);
      else
         win_n = NW'(win_size_ff);
      if (step_ff == 11'd0)
         step_n = 11'd1;
      else if (step_ff > 11'(STEP_MAX))
         step_n = 11'(STEP_MAX);
      else
         step_n = step_ff;
      prob_n = (prob_ff > 17'(PROB_ONE)) ? 17'(PROB_ONE) : prob_ff;
   end

   state_type state_ff, state_in;

   logic accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // series counters
   logic [ROW_BITS-1:0] slot_cnt_ff, slot_cnt_in;
   logic [9:0]          phase_ff, phase_in, phase_cur;
   logic [10:0]         phase_nx;
   logic                emit;
   logic [ROW_BITS-1:0] start_pos;
   logic [ROW_BITS-1:0] offset;

   always_comb begin
      if (req_tuser[1])
         slot_cnt_in = ROW_BITS'(1);
      else if (slot_cnt_ff == '1)
         slot_cnt_in = slot_cnt_ff;
      else
         slot_cnt_in = slot_cnt_ff + ROW_BITS'(1);
      phase_cur = req_tuser[1] ? 10'd0 : phase_ff;
      phase_nx  = {1'b0, phase_cur} + 11'd1;
      emit      = 1'b0;
      phase_in  = phase_cur;
      if (slot_cnt_in >= ROW_BITS'(win_n)) begin
         emit     = (phase_cur == 10'd0);
         phase_in = (phase_nx >= step_n) ? 10'd0 : phase_nx[9:0];
      end
      start_pos = slot_cnt_in - ROW_BITS'(win_n);
      case (align_ff)
         ALIGN_START: offset = '0;
         ALIGN_HALF:  offset = ROW_BITS'(win_n >> 1);
         default:     offset = ROW_BITS'(win_n) - ROW_BITS'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_cnt_ff <= '0;
         phase_ff    <= '0;
      end else if (accept) begin
         slot_cnt_ff <= slot_cnt_in;
         phase_ff    <= phase_in;
      end
   end

   // row index
   logic [ROW_BITS-1:0] row_plain_ff;
   logic                div_done;
   logic [ROW_BITS-1:0] div_quot;

   always_ff @(posedge clock) begin
      if (accept && emit)
         row_plain_ff <= start_pos + offset;
   end

   mwq_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && emit),
      .dividend (start_pos),
      .divisor  (step_n),
      .done     (div_done),
      .quotient (div_quot)
   );

   // cell chain
   cell_ctrl_type ctrl;
   logic signed [SB-1:0] cell_val  [WINDOW_MAX];
   logic                 cell_pres [WINDOW_MAX];
   logic signed [SB-1:0] circ_val  [WINDOW_MAX];
   logic                 circ_elig [WINDOW_MAX];
   logic                 circ_win  [WINDOW_MAX];
   logic [AW-1:0]        circ_tag  [WINDOW_MAX];

   always_comb begin
      ctrl.shift     = accept;
      ctrl.load_rank = (state_ff == ST_LOAD1);
      ctrl.load_pick = (state_ff == ST_LOAD2);
      ctrl.rank_en   = (state_ff == ST_RANK);
      ctrl.rotate    = (state_ff == ST_RANK) || (state_ff == ST_PICK);
   end

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      localparam int PREV = (i == 0) ? WINDOW_MAX - 1 : i - 1;
      mwq_cell #(
         .WINDOW_MAX  (WINDOW_MAX),
         .SAMPLE_BITS (SB),
         .POS         (i)
      ) u_cell (
         .clock          (clock),
         .ctrl           (ctrl),
         .window_n       (win_n),
         .prev_value     ((i == 0) ? $signed(req_tdata[SB-1:0]) : cell_val[PREV]),
         .prev_present   ((i == 0) ? req_tuser[0] : cell_pres[PREV]),
         .circ_value_in  (circ_val[PREV]),
         .circ_elig_in   (circ_elig[PREV]),
         .circ_win_in    (circ_win[PREV]),
         .circ_tag_in    (circ_tag[PREV]),
         .value_out      (cell_val[i]),
         .present_out    (cell_pres[i]),
         .circ_value_out (circ_val[i]),
         .circ_elig_out  (circ_elig[i]),
         .circ_win_out   (circ_win[i]),
         .circ_tag_out   (circ_tag[i])
      );
   end

   // sequencer
   logic [AW-1:0] cyc_ff;
   logic          last_cyc;
   assign last_cyc = (cyc_ff == AW'(WINDOW_MAX - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && emit) state_in = ST_LOAD1;
         ST_LOAD1: state_in = ST_RANK;
         ST_RANK:  if (last_cyc) state_in = ST_POS;
         ST_POS:   state_in = ST_LOAD2;
         ST_LOAD2: state_in = ST_PICK;
         ST_PICK:  if (last_cyc) state_in = ST_MUL;
         ST_MUL:   state_in = ST_DONE;
         ST_DONE:  if (div_done && (!rsp_tvalid || rsp_tready)) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cyc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_RANK) || (state_ff == ST_PICK))
            cyc_ff <= last_cyc ? '0 : cyc_ff + AW'(1);
         else
            cyc_ff <= '0;
      end
   end

   // tail of the chain: count the window, then pick the two neighbors
   logic [NW-1:0]         k_ff;
   logic                  any_miss_ff;
   logic [NW-1:0]         lo_ff;
   logic [FRAC_BITS-1:0]  frac_ff;
   logic                  use_hi_ff;
   logic signed [SB-1:0]  zlo_ff, zhi_ff;
   logic [NW+16:0]        pos_full;
   logic [NW-1:0]         tail_tag;

   assign tail_tag = NW'(circ_tag[WINDOW_MAX-1]);
   assign pos_full = (k_ff == '0) ? '0 :
                     (NW+17)'(k_ff - NW'(1)) * (NW+17)'(prob_n);

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD1) begin
         k_ff        <= '0;
         any_miss_ff <= 1'b0;
      end else if (state_ff == ST_RANK) begin
         if (circ_elig[WINDOW_MAX-1])
            k_ff <= k_ff + NW'(1);
         if (circ_win[WINDOW_MAX-1] && !circ_elig[WINDOW_MAX-1])
            any_miss_ff <= 1'b1;
      end
      if (state_ff == ST_POS) begin
         lo_ff     <= pos_full[NW+15:16];
         frac_ff   <= pos_full[15:0];
         use_hi_ff <= (pos_full[15:0] != '0) &&
                      ((pos_full[NW+15:16] + NW'(1)) < k_ff);
      end
      if ((state_ff == ST_PICK) && circ_elig[WINDOW_MAX-1]) begin
         if (tail_tag == lo_ff)
            zlo_ff <= circ_val[WINDOW_MAX-1];
         if (tail_tag == lo_ff + NW'(1))
            zhi_ff <= circ_val[WINDOW_MAX-1];
      end
   end

   // interpolation multiply, registered
   logic signed [SB:0]   diff;
   logic signed [PW-1:0] prod_ff;
   assign diff = {zhi_ff[SB-1], zhi_ff} - {zlo_ff[SB-1], zlo_ff};

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL)
         prod_ff <= PW'(diff * $signed({1'b0, frac_ff}));
   end

   logic signed [QW-1:0] qv;
   logic                 miss;
   assign qv   = ($signed(QW'(zlo_ff)) <<< FRAC_BITS) +
                 (use_hi_ff ? $signed(QW'(prod_ff)) : $signed(QW'(0)));
   assign miss = skip_ff ? (k_ff == '0) : any_miss_ff;

   // output register
   logic                  out_valid_ff;
   logic [ROW_BITS-1:0]   out_row_ff;
   logic [QUANT_BITS-1:0] out_q_ff;
   logic                  out_miss_ff;
   logic                  load_out;

   assign load_out = (state_ff == ST_DONE) && div_done && (!out_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (load_out)
         out_valid_ff <= 1'b1;
      else if (rsp_tready)
         out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_row_ff  <= compact_ff ? div_quot : row_plain_ff;
         out_q_ff    <= miss ? '0 : qv[QUANT_BITS-1:0];
         out_miss_ff <= miss;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_q_ff, out_row_ff};
   assign rsp_tuser  = out_miss_ff;

endmodule
`default_nettype wire

>>> src/mwq_checker.sv
// mwq_checker: port-level checks of the moving-window quantile unit, bound to the top level
// depends on mwq_pkg and moving_window_quantile_unit
`timescale 1ns / 1ps
`default_nettype none
module mwq_checker (
   input wire                                            clock,
   input wire                                            reset,
   input wire                                            req_tvalid,
   input wire                                            req_tready,
   input wire                                            rsp_tvalid,
   input wire                                            rsp_tready,
   input wire [mwq_pkg::ROW_BITS+mwq_pkg::QUANT_BITS-1:0] rsp_tdata,
   input wire [0:0]                                      rsp_tuser
);
   import mwq_pkg::*;

   // a missing result carries a zero quantile
   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[ROW_BITS+QUANT_BITS-1:ROW_BITS] == '0)
      else $error("missing result with nonzero quantile");

   // a result needs the chain passes, never the cycle after a slot transfer
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared right after a slot transfer");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

endmodule

bind moving_window_quantile_unit mwq_checker u_mwq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

>>> verif/tb.sv
// tb: self-checking bench for moving_window_quantile_unit, stream in and stream out
// predicts each quantile result in a scoreboard class; depends on mwq_pkg and the unit
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import mwq_pkg::*;

   localparam int WMAX = WINDOW_MAX_DEF;
   localparam longint CYCLE_LIMIT = 4000000;

   class quantile_scoreboard;
      int unsigned win_size, prob, step, skip, align, compact;
      logic signed [31:0] ring_val [WMAX];
      bit ring_ok [WMAX];
      int unsigned head, slots, phase;
      logic [31:0] exp_row [$];
      logic [47:0] exp_quant [$];
      bit exp_miss [$];
      int errors;

      function void clear_series();
         head = 0; slots = 0; phase = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] v);
         case (idx)
            REG_WINDOW_SIZE:   win_size = v[6:0];
            REG_QUANTILE_PROB: prob = v[16:0];
            REG_STEP_SIZE:     step = v[10:0];
            REG_SKIP_MISSING:  skip = v[0];
            REG_ALIGNMENT:     align = v[1:0];
            REG_COMPACT_INDEX: compact = v[0];
            default: ;
         endcase
      endfunction

      function new();
         win_size = 1; prob = 32768; step = 1; skip = 0; align = 0; compact = 0;
         errors = 0;
         clear_series();
      endfunction

      // one slot accepted; queue the quantile it produces, if any
      function void note_slot(logic signed [31:0] val, bit ok, bit first);
         logic signed [31:0] z [WMAX];
         int unsigned n, ss, p, k, lo, frac, pos, start, off, idx;
         bit any_miss, miss, emit;
         logic signed [31:0] v;
         logic [47:0] q;
         int j;
         if (first) clear_series();
         ring_val[head] = val; ring_ok[head] = ok;
         head = (head + 1) % WMAX;
         if (slots != 32'hFFFF_FFFF) slots++;
         n = (win_size == 0) ? 1 : ((win_size > WMAX) ? WMAX : win_size);
         ss = (step == 0) ? 1 : ((step > STEP_MAX) ? STEP_MAX : step);
         p = (prob > PROB_ONE) ? PROB_ONE : prob;
         if (slots < n) return;
         emit = (phase == 0);
         phase = (phase + 1 >= ss) ? 0 : phase + 1;
         if (!emit) return;
         k = 0; any_miss = 0; q = '0;
         for (int t = 0; t < n; t++) begin
            idx = (head + WMAX - n + t) % WMAX;
            if (ring_ok[idx]) begin z[k] = ring_val[idx]; k++; end
            else any_miss = 1;
         end
         miss = skip ? (k == 0) : any_miss;
         if (!miss) begin
            for (int t = 1; t < k; t++) begin
               v = z[t]; j = t;
               while (j > 0 && z[j-1] > v) begin z[j] = z[j-1]; j--; end
               z[j] = v;
            end
            pos = (k - 1) * p;
            lo = pos >> 16;
            frac = pos & 16'hFFFF;
            if (lo >= k) lo = k - 1;
            q = {{16{z[lo][31]}}, z[lo]} << 16;
            if (frac != 0 && lo + 1 < k)
               q = q + ({{16{z[lo+1][31]}}, z[lo+1]} - {{16{z[lo][31]}}, z[lo]})
                       * 48'(frac);
         end
         start = slots - n;
         off = (align == 0) ? 0 : ((align == 1) ? n / 2 : n - 1);
         exp_row.push_back(compact ? start / ss : start + off);
         exp_quant.push_back(miss ? 48'd0 : q);
         exp_miss.push_back(miss);
      endfunction

      function void check_result(logic [31:0] row, logic [47:0] qv, bit miss);
         logic [31:0] er;
         logic [47:0] eq;
         bit em;
         if (exp_row.size() == 0) begin
            $display("%0t: unexpected result row %0d value %h", $time, row, qv);
            errors++;
            return;
         end
         er = exp_row.pop_front(); eq = exp_quant.pop_front(); em = exp_miss.pop_front();
         if (row !== er) begin
            $display("%0t: row_index expected %0d actual %0d", $time, er, row); errors++;
         end
         if (qv !== eq) begin
            $display("%0t: quantile_value expected %h actual %h", $time, eq, qv); errors++;
         end
         if (miss !== em) begin
            $display("%0t: quantile_missing expected %0d actual %0d", $time, em, miss);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0, csr_we = 0;
   logic [31:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   wire req_tready, rsp_tvalid;
   wire [ROW_BITS+QUANT_BITS-1:0] rsp_tdata;
   wire [0:0] rsp_tuser;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   int send_idle = 0, recv_stall = 0;
   longint cycles = 0;
   quantile_scoreboard board = new();

   moving_window_quantile_unit uut (.*);

   always begin #10 clock = 1; #10 clock = 0; end

   // rising edge: note transfers and check results
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_slot(req_tdata, req_tuser[0], req_tuser[1]);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata[31:0], rsp_tdata[79:32], rsp_tuser[0]);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver drives tready at falling edges
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall);

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, int unsigned v);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= CSR_DATA_BITS'(v);
      board.set_reg(idx, CSR_DATA_BITS'(v));
      @(negedge clock);
      csr_we <= 0;
   endtask

   // tvalid stays up after a transfer; the next slot, an idle cycle or drain replaces it
   task automatic send_slot(logic [31:0] val, bit ok, bit first);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1; req_tdata <= val; req_tuser <= {first, ok};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // wait until every result is in, then let the unit go quiet
   task automatic drain();
      req_tvalid <= 0;
      while (board.exp_row.size() != 0) @(negedge clock);
      repeat (2 * WMAX + 50) @(negedge clock);
   endtask

   task automatic setup(int unsigned w, int unsigned p, int unsigned s,
                        int unsigned sk, int unsigned al, int unsigned cm);
      drain();
      write_reg(REG_WINDOW_SIZE, w);
      write_reg(REG_QUANTILE_PROB, p);
      write_reg(REG_STEP_SIZE, s);
      write_reg(REG_SKIP_MISSING, sk);
      write_reg(REG_ALIGNMENT, al);
      write_reg(REG_COMPACT_INDEX, cm);
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return $urandom_range(20) - 10;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_run(int count, int miss_pct);
      for (int i = 0; i < count; i++)
         send_slot(rand_sample(), $urandom_range(99) >= miss_pct,
                   i == 0 || $urandom_range(199) == 0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes, missing slots, series restarts
      setup(3, 65536, 1, 0, 2, 0);
      send_slot(32'h7FFF_FFFF, 1, 1);
      send_slot(32'h8000_0000, 1, 0);
      send_slot(32'hFFFF_FFFF, 1, 0);
      send_slot(32'd5, 0, 0);
      send_slot(32'd7, 1, 0);
      send_slot(32'd9, 1, 0);
      setup(4, 0, 2, 1, 1, 1);
      for (int i = 0; i < 6; i++) send_slot(i * 3, i != 2, i == 0);
      for (int i = 0; i < 5; i++) send_slot(32'h8000_0000, 0, i == 0);
      setup(0, 131071, 0, 0, 3, 0);
      send_slot(32'h8000_0000, 1, 1);
      send_slot(32'h7FFF_FFFF, 1, 1);
      send_slot(32'd1, 1, 0);
      setup(127, 21845, 2047, 1, 0, 1);
      random_run(70, 10);
      // random phases with varied settings and idling
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? 82 : 0;
         recv_stall = (ph == 2 || ph == 3) ? 82 : 0;
         if (ph == 3) begin send_idle = 12; recv_stall = 12; end
         setup(64, $urandom_range(65536), 1, 1, $urandom_range(2), 0);
         random_run(80, 20);
         setup($urandom_range(1, 8), $urandom_range(65536), $urandom_range(1, 3),
               $urandom_range(1), $urandom_range(3), $urandom_range(1));
         random_run(110, 15);
         setup($urandom_range(1, 64), $urandom_range(65536), 1, 0,
               $urandom_range(2), $urandom_range(1));
         random_run(70, 3);
      end
      drain();
      if (board.errors == 0 && board.exp_row.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
